[src/tpa_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for triangle primitive assembly
package tpa_pkg;

   localparam int INDEX_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef enum logic [1:0] {
      MODE_LIST  = 2'd0,
      MODE_STRIP = 2'd1,
      MODE_FAN   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic {
      CMD_BEGIN  = 1'b0,
      CMD_VERTEX = 1'b1
   } cmd_kind_type;

   // classified item handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      mode_type     mode;
      index_type    index;
   } cmd_type;

   typedef struct packed {
      logic                      empty;
      logic                      full;
      logic [QUEUE_CNT_BITS-1:0] count;
   } queue_stat_type;

endpackage

[src/tpa_req_if.sv]
`timescale 1ns / 1ps
// input channel: contour begin or vertex index
interface tpa_req_if;
   import tpa_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   logic [1:0] prim_type;
   index_type vertex_index;

   modport source (output valid, output op, output prim_type, output vertex_index,
                   input ready);
   modport sink (input valid, input op, input prim_type, input vertex_index,
                 output ready);
endinterface

[src/tpa_rsp_if.sv]
`timescale 1ns / 1ps
// result channel: three corner indices of one triangle
interface tpa_rsp_if;
   import tpa_pkg::*;

   logic      valid;
   logic      ready;
   index_type corner_a;
   index_type corner_b;
   index_type corner_c;

   modport source (output valid, output corner_a, output corner_b, output corner_c,
                   input ready);
   modport sink (input valid, input corner_a, input corner_b, input corner_c,
                 output ready);
endinterface

[src/tpa_front.sv]
`timescale 1ns / 1ps
// front end: accepts items, tracks contour type, drops items that cannot emit
module tpa_front (
   input  logic                    clock,
   input  logic                    reset,
   tpa_req_if.sink                 req,
   input  tpa_pkg::queue_stat_type q_stat,
   output logic                    push,
   output tpa_pkg::cmd_type        push_cmd
);
   import tpa_pkg::*;

   mode_type mode_ff;
   mode_type mode_in;
   mode_type begin_mode;
   logic     accept;
   logic     keep;

   assign req.ready = !q_stat.full;
   assign accept = req.valid && req.ready;
   assign begin_mode = mode_type'(req.prim_type);

   always_comb begin
      mode_in = mode_ff;
      keep = 1'b0;
      if (req.op == OP_BEGIN) begin
         mode_in = begin_mode;
         // an unsupported begin leaves nothing for the back end to do
         keep = (begin_mode != MODE_NONE);
      end else begin
         keep = (mode_ff != MODE_NONE);
      end
   end

   assign push = accept && keep;

   always_comb begin
      push_cmd.kind = (req.op == OP_BEGIN) ? CMD_BEGIN : CMD_VERTEX;
      push_cmd.mode = (req.op == OP_BEGIN) ? begin_mode : mode_ff;
      push_cmd.index = req.vertex_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

[src/tpa_cmd_queue.sv]
`timescale 1ns / 1ps
// short command queue between front and back ends
module tpa_cmd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tpa_pkg::cmd_type         push_cmd,
   input  logic                     pop,
   output tpa_pkg::cmd_type         head_cmd,
   output tpa_pkg::queue_stat_type  q_stat
);
   import tpa_pkg::*;

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;

   localparam logic [QUEUE_CNT_BITS-1:0] CountFull = QUEUE_CNT_BITS'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_BITS-1:0] PtrLast = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

   always_comb begin
      q_stat.count = count_ff;
      q_stat.empty = (count_ff == '0);
      q_stat.full = (count_ff == CountFull);
   end

   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/tpa_back.sv]
`timescale 1ns / 1ps
// back end: held indices, strip parity, triangle emission and output register
module tpa_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tpa_pkg::cmd_type        head_cmd,
   input  tpa_pkg::queue_stat_type q_stat,
   output logic                    pop,
   tpa_rsp_if.source               rsp
);
   import tpa_pkg::*;

   index_type first_ff, first_in;
   index_type second_ff, second_in;
   logic      first_valid_ff, first_valid_in;
   logic      second_valid_ff, second_valid_in;
   logic      parity_ff, parity_in;
   logic      rsp_valid_ff, rsp_valid_in;
   index_type corner_a_ff, corner_a_in;
   index_type corner_b_ff, corner_b_in;
   index_type corner_c_ff, corner_c_in;
   logic      emit;

   // take the next command whenever the output register can accept a result
   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      first_in = first_ff;
      second_in = second_ff;
      first_valid_in = first_valid_ff;
      second_valid_in = second_valid_ff;
      parity_in = parity_ff;
      emit = 1'b0;
      corner_a_in = first_ff;
      corner_b_in = head_cmd.index;
      corner_c_in = second_ff;
      if (head_cmd.kind == CMD_BEGIN) begin
         first_in = '0;
         second_in = '0;
         first_valid_in = 1'b0;
         second_valid_in = 1'b0;
         parity_in = 1'b0;
      end else if (!first_valid_ff) begin
         first_in = head_cmd.index;
         first_valid_in = 1'b1;
      end else if (!second_valid_ff) begin
         second_in = head_cmd.index;
         second_valid_in = 1'b1;
      end else begin
         emit = 1'b1;
         unique case (head_cmd.mode)
            MODE_LIST: begin
               first_in = '0;
               second_in = '0;
               first_valid_in = 1'b0;
               second_valid_in = 1'b0;
            end
            MODE_STRIP: begin
               if (parity_ff) begin
                  corner_b_in = second_ff;
                  corner_c_in = head_cmd.index;
               end
               first_in = second_ff;
               second_in = head_cmd.index;
               parity_in = !parity_ff;
            end
            MODE_FAN: begin
               second_in = head_cmd.index;
            end
            default: begin
               // no contour: the front end never passes such a vertex
               emit = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = (pop && emit) || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         second_ff <= '0;
         first_valid_ff <= 1'b0;
         second_valid_ff <= 1'b0;
         parity_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            first_ff <= first_in;
            second_ff <= second_in;
            first_valid_ff <= first_valid_in;
            second_valid_ff <= second_valid_in;
            parity_ff <= parity_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         corner_a_ff <= corner_a_in;
         corner_b_ff <= corner_b_in;
         corner_c_ff <= corner_c_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.corner_a = corner_a_ff;
   assign rsp.corner_b = corner_b_ff;
   assign rsp.corner_c = corner_c_ff;

endmodule

[src/triangle_primitive_assembly.sv]
`timescale 1ns / 1ps
// triangle primitive assembly top level: front end, command queue, back end
//
//  channel    dir  handshake    payload
//  req_chan   in   valid/ready  op, prim_type, vertex_index
//  rsp_chan   out  valid/ready  corner_a, corner_b, corner_c
//
// one item per clock sustained while rsp_chan keeps accepting; after its vertex transfer a triangle
// passes through a queue entry, then the output register
// synchronous reset clears contour type to none, held flags, parity, queue and output valid
// req_chan.ready drops only when the four-entry command queue is full
// the back end stalls only while a finished triangle waits in the output register
module triangle_primitive_assembly (
   input  logic     clock,
   input  logic     reset,
   tpa_req_if.sink  req_chan,
   tpa_rsp_if.source rsp_chan
);
   import tpa_pkg::*;

   // front to queue
   logic           push;
   cmd_type        push_cmd;
   // queue to back
   logic           pop;
   cmd_type        head_cmd;
   queue_stat_type q_stat;

   // classify items and track the current contour type
   tpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // decouples input acceptance from result stalls
   tpa_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   // held indices, strip parity and triangle emission
   tpa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   // input is held off exactly when the queue is full
   a_ready_tracks_full: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready == !q_stat.full)
      else $error("input ready does not follow queue occupancy");

   // queue never pops when empty
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty command queue");

   // occupancy grows by one on a lone push
   a_count_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> q_stat.count == $past(q_stat.count) + 1'b1)
      else $error("command queue count lost a push");

   // a waiting triangle blocks the back end
   a_stall_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !pop)
      else $error("command consumed while result stalled");

endmodule

[tb/triangle_primitive_assembly_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for triangle primitive assembly: list, strip and fan contours
module triangle_primitive_assembly_test;
   import tpa_pkg::*;

   // run limits, in clock cycles
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 10;

   // one input item as the sender sees it
   typedef struct {
      logic      op;
      mode_type  prim;
      index_type vertex_index;
   } tpa_item_type;

   // one emitted triangle
   typedef struct {
      index_type a;
      index_type b;
      index_type c;
   } triangle_type;

   logic clock;
   logic reset;

   tpa_req_if req_bus ();
   tpa_rsp_if rsp_bus ();

   triangle_primitive_assembly u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // items waiting for the driver, triangles waiting for the monitor
   tpa_item_type pending_items[$];
   triangle_type expected_triangles[$];
   tpa_item_type shown_item;

   // idle percentages per side, changed between phases
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // long receiver hold-offs: asked by the stimulus, served by the ready process
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;

   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   // assembler state as predicted from the accepted transfers
   mode_type  asm_mode = MODE_NONE;
   index_type first_idx = '0;
   logic      first_ok = 1'b0;
   index_type second_idx = '0;
   logic      second_ok = 1'b0;
   logic      odd_face = 1'b0;

   // clock, reset, and known input levels from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_BEGIN;
      req_bus.prim_type = MODE_NONE;
      req_bus.vertex_index = '0;
      rsp_bus.ready = 1'b0;
      fork
         forever #6 clock = ~clock;
         begin
            repeat (7) @(posedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   // predictor: one accepted item in, zero or one triangle out
   task automatic assemble_step(input tpa_item_type item);
      triangle_type face;
      index_type v;
      v = item.vertex_index;
      if (item.op == OP_BEGIN) begin
         // a begin drops whatever is held, mid-contour too
         asm_mode = item.prim;
         first_idx = '0;
         first_ok = 1'b0;
         second_idx = '0;
         second_ok = 1'b0;
         odd_face = 1'b0;
      end else if (asm_mode != MODE_NONE) begin
         if (!first_ok) begin
            first_idx = v;
            first_ok = 1'b1;
         end else if (!second_ok) begin
            second_idx = v;
            second_ok = 1'b1;
         end else begin
            case (asm_mode)
               MODE_LIST: begin
                  face = '{first_idx, v, second_idx};
                  first_idx = '0;
                  first_ok = 1'b0;
                  second_idx = '0;
                  second_ok = 1'b0;
               end
               MODE_STRIP: begin
                  // winding flips on every other face
                  if (odd_face)
                     face = '{first_idx, second_idx, v};
                  else
                     face = '{first_idx, v, second_idx};
                  first_idx = second_idx;
                  second_idx = v;
                  odd_face = ~odd_face;
               end
               default: begin
                  // fan keeps its hub in first
                  face = '{first_idx, v, second_idx};
                  second_idx = v;
               end
            endcase
            expected_triangles.push_back(face);
         end
      end
   endtask

   // stimulus helpers; the field that the op ignores gets random content
   function automatic void queue_begin(input mode_type prim);
      tpa_item_type item;
      item.op = OP_BEGIN;
      item.prim = prim;
      item.vertex_index = index_type'($urandom);
      pending_items.push_back(item);
   endfunction

   function automatic void queue_vertex(input index_type idx);
      tpa_item_type item;
      item.op = OP_VERTEX;
      item.prim = mode_type'($urandom_range(3));
      item.vertex_index = idx;
      pending_items.push_back(item);
   endfunction

   function automatic index_type pick_index();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)
         return '0;
      else if (r < 16)
         return '1;
      return index_type'($urandom);
   endfunction

   // mostly well-formed contours with random content, some noise items
   task automatic queue_random_contours(input int unsigned target);
      int unsigned start;
      int unsigned r;
      int unsigned n;
      tpa_item_type item;
      mode_type prim;
      start = pending_items.size();
      while (pending_items.size() - start < target) begin
         r = $urandom_range(99);
         if (r < 8) begin
            // noise: any op with any fields
            item.op = logic'($urandom_range(1));
            item.prim = mode_type'($urandom_range(3));
            item.vertex_index = index_type'($urandom);
            pending_items.push_back(item);
         end else begin
            if ($urandom_range(99) < 8)
               prim = MODE_NONE;
            else
               prim = mode_type'($urandom_range(2));
            queue_begin(prim);
            // mostly short contours, now and then a long one
            if ($urandom_range(99) < 15)
               n = $urandom_range(30, 10);
            else
               n = $urandom_range(9);
            repeat (n) queue_vertex(pick_index());
         end
      end
   endtask

   // sender pause: nothing left to offer and nothing still expected
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_triangles.size() != 0);
   endtask

   // driver: presents queued items, predicts on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            assemble_step(shown_item);
         // a new item may go out once the current one is taken or none is shown
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               shown_item = pending_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op <= shown_item.op;
               req_bus.prim_type <= shown_item.prim;
               req_bus.vertex_index <= shown_item.vertex_index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver ready: random idling, or a long hold-off when one is asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_served + 1;
         hold_left = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void check_corner(input string which, input index_type want,
                                        input index_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, which, want, got);
         mismatches++;
      end
   endfunction

   // monitor: each result transfer against the oldest expected triangle
   always @(posedge clock) begin
      triangle_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_triangles.size() == 0) begin
            $display("%0t: unexpected triangle, expected none actual %h %h %h", $time,
                     rsp_bus.corner_a, rsp_bus.corner_b, rsp_bus.corner_c);
            mismatches++;
         end else begin
            want = expected_triangles.pop_front();
            check_corner("corner_a", want.a, rsp_bus.corner_a);
            check_corner("corner_b", want.b, rsp_bus.corner_b);
            check_corner("corner_c", want.c, rsp_bus.corner_c);
         end
      end
   end

   // timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // stimulus phases
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // phase one: sender idles little, receiver a lot
      send_idle_pct = 24;
      recv_idle_pct = 61;

      // vertex before any begin is dropped
      queue_vertex(16'h1234);
      // unsupported type drops vertices
      queue_begin(MODE_NONE);
      queue_vertex(16'd5);
      queue_vertex(16'd6);
      queue_vertex(16'd7);
      // list with index extremes, two faces, then two held vertices cut off by a begin
      queue_begin(MODE_LIST);
      queue_vertex(16'h0000);
      queue_vertex(16'hFFFF);
      queue_vertex(16'h0001);
      queue_vertex(16'h0002);
      queue_vertex(16'h0003);
      queue_vertex(16'h0004);
      queue_vertex(16'h8000);
      queue_vertex(16'h7FFF);
      // strip: three faces cover both windings
      queue_begin(MODE_STRIP);
      queue_vertex(16'd10);
      queue_vertex(16'd11);
      queue_vertex(16'd12);
      queue_vertex(16'd13);
      queue_vertex(16'd14);
      // fan: hub stays, second slides
      queue_begin(MODE_FAN);
      queue_vertex(16'd20);
      queue_vertex(16'd21);
      queue_vertex(16'd22);
      queue_vertex(16'd23);
      queue_random_contours(170);
      wait_drained();

      // long receiver hold-off against a long fan so the input backs up
      holds_asked = holds_asked + 1;
      queue_begin(MODE_FAN);
      repeat (60) queue_vertex(pick_index());
      wait_drained();

      // phase two: roles swapped
      send_idle_pct = 61;
      recv_idle_pct = 24;
      queue_random_contours(150);
      wait_drained();

      // phase three: full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_contours(150);
      wait_drained();

      // let any trailing transfer show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_triangles.size() != 0) begin
         $display("%0t: %0d expected triangles never arrived", $time,
                  expected_triangles.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
